[sv/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_OK         = 2'd1,
    KIND_BAD        = 2'd2,
    KIND_INCOMPLETE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_ALPHA = 2'd0,
    CLS_PAD   = 2'd1,
    CLS_SPACE = 2'd2,
    CLS_BAD   = 2'd3
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [5:0] value;
  } char_class_t;

  // One run: every result that a single input character causes.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      n_data;
    logic            has_status;
    kind_e           status;
  } run_t;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [5:0] VAL_PLUS   = 6'd62;
  localparam logic [5:0] VAL_SLASH  = 6'd63;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.cls   = CLS_BAD;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.cls   = CLS_ALPHA;
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.cls   = CLS_ALPHA;
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.cls   = CLS_ALPHA;
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r.cls   = CLS_ALPHA;
      r.value = VAL_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.cls   = CLS_ALPHA;
      r.value = VAL_SLASH;
    end else if (c == CHAR_EQ) begin
      r.cls   = CLS_PAD;
    end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
      r.cls   = CLS_SPACE;
    end
    return r;
  endfunction

endpackage

[sv/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, gathers groups of four and forms result runs.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  input  logic       accept_i,
  output logic       run_valid_o,
  output run_t       run_o
);

  logic [2:0][5:0] sext_q;
  logic [1:0]      count_q, count_d;
  logic            third_pad_q;
  logic            error_q;

  char_class_t cc;
  logic        is_pad, is_bad, gather, complete;
  logic [5:0]  v;
  logic        err_now;

  always_comb begin
    cc       = classify(text_char_i);
    is_pad   = (cc.cls == CLS_PAD);
    is_bad   = (cc.cls == CLS_BAD);
    v        = is_pad ? 6'd0 : cc.value;
    gather   = !is_bad && (cc.cls != CLS_SPACE) && !error_q;
    complete = gather && (count_q == 2'd3);
    err_now  = error_q || is_bad;

    if (gather) begin
      count_d = complete ? 2'd0 : count_q + 2'd1;
    end else begin
      count_d = count_q;
    end

    run_o.data[0] = {sext_q[0], sext_q[1][5:4]};
    run_o.data[1] = {sext_q[1][3:0], sext_q[2][5:2]};
    run_o.data[2] = {sext_q[2][1:0], v};
    if (!complete) begin
      run_o.n_data = 2'd0;
    end else if (!is_pad) begin
      run_o.n_data = 2'd3;
    end else if (third_pad_q) begin
      run_o.n_data = 2'd1;
    end else begin
      run_o.n_data = 2'd2;
    end
    run_o.has_status = end_of_text_i;
    if (err_now) begin
      run_o.status = KIND_BAD;
    end else if (count_d != 2'd0) begin
      run_o.status = KIND_INCOMPLETE;
    end else begin
      run_o.status = KIND_OK;
    end
    run_valid_o = accept_i && (complete || end_of_text_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sext_q      <= '0;
      count_q     <= '0;
      third_pad_q <= 1'b0;
      error_q     <= 1'b0;
    end else if (accept_i) begin
      if (end_of_text_i) begin
        sext_q      <= '0;
        count_q     <= '0;
        third_pad_q <= 1'b0;
        error_q     <= 1'b0;
      end else begin
        count_q <= count_d;
        error_q <= err_now;
        for (int i = 0; i < 3; i++) begin
          if (gather && !complete && count_q == 2'(i)) begin
            sext_q[i] <= v;
          end
        end
        if (gather && count_q == 2'd2) begin
          third_pad_q <= is_pad;
        end
      end
    end
  end

endmodule

[sv/b64d_queue.sv]
// ----------------------------------------------------------------------------
// b64d_queue
// Short run queue between the classifying front and the result serializer.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  run_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output run_t rd_data_o,
  output logic empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);

  run_t          mem [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o    = (count_q == CW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[sv/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back
// Serializes each run into result beats, one beat per cycle while pop is high.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  run_t       q_data_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] result_kind_o,
  output logic       last_of_run_o
);

  run_t       run_q;
  logic [1:0] pos_q;
  logic       valid_q;
  logic [2:0] total;
  logic       is_last;
  logic       take;

  always_comb begin
    total   = {1'b0, run_q.n_data} + {2'b00, run_q.has_status};
    is_last = ({1'b0, pos_q} == total - 3'd1);

    if (pos_q < run_q.n_data) begin
      result_kind_o = KIND_DATA;
      case (pos_q)
        2'd0:    out_byte_o = run_q.data[0];
        2'd1:    out_byte_o = run_q.data[1];
        default: out_byte_o = run_q.data[2];
      endcase
    end else begin
      result_kind_o = run_q.status;
      out_byte_o    = '0;
    end
    last_of_run_o = is_last;
    empty         = !valid_q;

    // The next run loads as the last beat of the current one leaves.
    take    = !q_empty_i && (!valid_q || (pop && is_last));
    q_pop_o = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
      run_q   <= '0;
    end else if (take) begin
      valid_q <= 1'b1;
      pos_q   <= '0;
      run_q   <= q_data_i;
    end else if (valid_q && pop) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 2'd1;
      end
    end
  end

endmodule

[sv/base64_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder with per-message status.
// ----------------------------------------------------------------------------
// One text character is taken per cycle while full is low. Whitespace is
// skipped, every fourth valid character releases one to three decoded bytes,
// and a character marked end_of_text adds a final status beat (ok, bad
// character or incomplete group) and returns the decoder to its reset state.
// Results leave one beat per cycle while pop is asserted; all beats caused by
// one character are contiguous and the last one carries last_of_run. The
// front classifies each character in the cycle it is pushed; runs of results
// wait in a RunDepth-entry queue, and full rises only when that queue is full,
// which happens when the result side stalls. The first beat caused by a
// character appears, at the earliest, once its run passed the queue and run_q.
module base64_stream_decoder_unit
  import b64d_pkg::*;
#(
  parameter int RunDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] result_kind_o,
  output logic       last_of_run_o
);

  logic accept;
  logic run_valid;
  run_t run_in, run_out;
  logic q_empty, q_pop;

  assign accept = push && !full;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .accept_i      (accept),
    .run_valid_o   (run_valid),
    .run_o         (run_in)
  );

  b64d_queue #(
    .Depth (RunDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (run_valid),
    .wr_data_i (run_in),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .rd_data_o (run_out),
    .empty_o   (q_empty)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (run_out),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .result_kind_o (result_kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
